// ===== rtl/satq_pkg.sv =====
package satq_pkg;

    localparam int NUM_PROCS   = 16;
    localparam int TPS         = 100;
    localparam int MS_PER_S    = 1000;
    localparam int MS_PER_TICK = MS_PER_S / TPS;
    localparam int ROUND_MS    = MS_PER_S / 2;
    localparam int BIG_MS      = 1000000000 / TPS;
    localparam int MAX_NOTES   = 16;
    localparam int PID_W       = 4;
    localparam int TW          = 32;
    // x / MS_PER_S == (x * RECIP) >> RECIP_SH for every 32-bit x
    localparam int RECIP_SH    = 38;
    localparam int RECIP       = int'(((longint'(1) << RECIP_SH) + longint'(MS_PER_S - 1))
                                      / longint'(MS_PER_S));
    localparam int RECIP_W     = $clog2(RECIP);
    localparam int NOTE_W      = $clog2(MAX_NOTES + 1);

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_SET   = 1'b1;
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_NOTE  = 1'b1;

    typedef logic [TW-1:0] tm_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_POP,
        OP_UNLINK,
        OP_CANCEL,
        OP_INSERT
    } op_t;

    typedef struct packed {
        logic             valid;
        logic [PID_W-1:0] pid;
        tm_t              dl;
    } ent_t;

    typedef struct packed {
        op_t              op;
        logic [PID_W-1:0] pid;
        tm_t              when;
    } ctl_t;

    // a - b >= 0 as a signed wrapping difference
    function automatic logic reached(input tm_t a, input tm_t b);
        tm_t d;
        d = a - b;
        return !d[TW-1];
    endfunction

endpackage

// ===== rtl/satq_cell.sv =====
module satq_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  satq_pkg::ctl_t ctl,
    input  satq_pkg::ent_t left_ent,
    input  satq_pkg::ent_t right_ent,
    input  logic           match_seen_in,
    input  logic           ins_seen_in,
    output satq_pkg::ent_t ent,
    output logic           hit,
    output logic           match_seen_out,
    output logic           ins_seen_out
);
    import satq_pkg::*;

    ent_t ent_reg;
    ent_t ent_next;
    logic at;

    assign hit = ent_reg.valid && (ent_reg.pid == ctl.pid);
    // first slot that is free or holds an armed deadline at or after the new one
    assign at  = !ent_reg.valid || ((ent_reg.dl != '0) && reached(ent_reg.dl, ctl.when));

    assign match_seen_out = match_seen_in | hit;
    assign ins_seen_out   = ins_seen_in | at;
    assign ent            = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctl.op)
            OP_POP:
            begin
                ent_next = right_ent;
            end
            OP_UNLINK:
            begin
                if (match_seen_in || hit)
                begin
                    ent_next = right_ent;
                end
            end
            OP_CANCEL:
            begin
                if (hit)
                begin
                    ent_next.dl = '0;
                end
            end
            OP_INSERT:
            begin
                if (ins_seen_in)
                begin
                    ent_next = left_ent;
                end
                else if (at)
                begin
                    ent_next = '{valid: 1'b1, pid: ctl.pid, dl: ctl.when};
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

// ===== rtl/satq_chain.sv =====
module satq_chain (
    input  logic                               clk,
    input  logic                               rst_n,
    input  satq_pkg::ctl_t                     ctl,
    output satq_pkg::ent_t                     head,
    output satq_pkg::tm_t                      look_dl,
    output logic [satq_pkg::NUM_PROCS-1:0]     valid_vec
);
    import satq_pkg::*;

    ent_t                 ent_pad [NUM_PROCS+2];
    logic [NUM_PROCS-1:0] hits;
    logic [NUM_PROCS:0]   mseen;
    logic [NUM_PROCS:0]   iseen;

    assign ent_pad[0]           = '0;
    assign ent_pad[NUM_PROCS+1] = '0;
    assign mseen[0]             = 1'b0;
    assign iseen[0]             = 1'b0;

    genvar i;
    generate
        for (i = 0; i < NUM_PROCS; i++)
        begin : g_cell
            satq_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .ctl            (ctl),
                .left_ent       (ent_pad[i]),
                .right_ent      (ent_pad[i+2]),
                .match_seen_in  (mseen[i]),
                .ins_seen_in    (iseen[i]),
                .ent            (ent_pad[i+1]),
                .hit            (hits[i]),
                .match_seen_out (mseen[i+1]),
                .ins_seen_out   (iseen[i+1])
            );
            assign valid_vec[i] = ent_pad[i+1].valid;
        end
    endgenerate

    assign head = ent_pad[1];

    // at most one slot holds a given process
    always_comb
    begin
        look_dl = '0;
        for (int k = 0; k < NUM_PROCS; k++)
        begin
            if (hits[k])
            begin
                look_dl = look_dl | ent_pad[k+1].dl;
            end
        end
    end

endmodule

// ===== rtl/satq_div.sv =====
module satq_div (
    input  logic           clk,
    input  logic           start,
    input  satq_pkg::tm_t  dividend,
    output satq_pkg::tm_t  quotient
);
    import satq_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic [TW+RECIP_W-1:0] prod_reg;

    // divide by MS_PER_S through reciprocal multiplication, result in the cycle after start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{RECIP_W{1'b0}}, dividend} * {{TW{1'b0}}, RECIP_K};
        end
    end

    assign quotient = tm_t'(prod_reg[TW+RECIP_W-1:RECIP_SH]);

endmodule

// ===== rtl/sorted_alarm_timer_queue.sv =====
// Set item: lookup, scaling, reciprocal divide, fix-up, deadline and insert; then the reply
// is loaded and only then is the next item taken. An out-of-range proc_id goes to the reply.
// Tick item: drops one head entry per cycle unless the output stalls it, then stops;
// notes trail the walk by one entry, the final one leaves as the walk stops.
// A result the receiver has not taken stalls the walk and the reply.
// Reset (async, active low) clears the tick counter, queue and output valid; ready at once.
module sorted_alarm_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] proc_id, [35:4] delay_ms, [39:36] zero
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] proc_id_out, [35:4] old_remaining_ms, [39:36] zero
    output logic        m_tuser,   // kind
    output logic        m_tlast    // last
);
    import satq_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TICK  = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIVS  = 9'b000010000,
        S_FIX   = 9'b000100000,
        S_WHEN  = 9'b001000000,
        S_INS   = 9'b010000000,
        S_REPLY = 9'b100000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    tm_t                 tick_reg;
    tm_t                 tick_next;
    logic [NOTE_W-1:0]   note_cnt_reg;
    logic [NOTE_W-1:0]   note_cnt_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    logic [PID_W-1:0]    pend_pid_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_kind_reg;
    logic [PID_W-1:0]    out_pid_reg;
    tm_t                 out_ms_reg;
    logic                out_last_reg;

    logic [PID_W-1:0]    set_pid_reg;
    tm_t                 ms_reg;
    tm_t                 rem_reg;
    logic                alive_reg;
    logic                big_reg;
    tm_t                 div_in_reg;
    tm_t                 old_ms_reg;
    tm_t                 ticks_reg;
    tm_t                 when_reg;

    ctl_t                ctl;
    ent_t                head;
    tm_t                 look_dl;
    logic [NUM_PROCS-1:0] valid_vec;
    tm_t                 q_ms;

    logic                s_xfer;
    logic                pid_oor;
    logic                out_free;
    logic                ms_zero;
    logic                big;
    logic                head_armed;
    logic                walk_stop;
    logic                pend_take;
    logic                out_load;
    logic                out_kind;
    logic [PID_W-1:0]    out_pid;
    tm_t                 out_ms;
    logic                out_last;
    tm_t                 when_sum;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign pid_oor  = int'(s_tdata[PID_W-1:0]) >= NUM_PROCS;
    assign out_free = !out_valid_reg || m_tready;
    assign ms_zero  = (ms_reg == '0);
    assign big      = (ms_reg >= tm_t'(BIG_MS));
    assign when_sum = ticks_reg + tick_reg;

    assign head_armed = head.valid && (head.dl != '0);
    assign walk_stop  = !head.valid ||
                        (head_armed && (!reached(tick_reg, head.dl) ||
                                        (note_cnt_reg == NOTE_W'(MAX_NOTES))));

    satq_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .head      (head),
        .look_dl   (look_dl),
        .valid_vec (valid_vec)
    );

    satq_div u_div_ms (
        .clk      (clk),
        .start    (state_reg == S_DIVS),
        .dividend (div_in_reg),
        .quotient (q_ms)
    );

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        note_cnt_next   = note_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_take       = 1'b0;
        out_load        = 1'b0;
        out_kind        = KIND_NOTE;
        out_pid         = pend_pid_reg;
        out_ms          = '0;
        out_last        = 1'b0;
        ctl             = '{op: OP_NOP, pid: set_pid_reg, when: when_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    if (s_tuser == FUNC_TICK)
                    begin
                        tick_next       = tick_reg + 1'b1;
                        note_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_TICK;
                    end
                    else if (pid_oor)
                    begin
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_TICK:
            begin
                if (walk_stop)
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_last        = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (!head_armed)
                begin
                    ctl.op = OP_POP;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    ctl.op          = OP_POP;
                    out_load        = pend_valid_reg;
                    pend_take       = 1'b1;
                    pend_valid_next = 1'b1;
                    note_cnt_next   = note_cnt_reg + 1'b1;
                end
            end
            S_LOOK:
            begin
                ctl.op     = ms_zero ? OP_CANCEL : OP_UNLINK;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                state_next = S_FIX;
            end
            S_FIX:
            begin
                state_next = S_WHEN;
            end
            S_WHEN:
            begin
                state_next = S_INS;
            end
            S_INS:
            begin
                ctl.op     = ms_zero ? OP_NOP : OP_INSERT;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_REPLY;
                    out_pid    = set_pid_reg;
                    out_ms     = old_ms_reg;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            note_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            note_cnt_reg   <= note_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= out_kind;
            out_pid_reg  <= out_pid;
            out_ms_reg   <= out_ms;
            out_last_reg <= out_last;
        end
        if (pend_take)
        begin
            pend_pid_reg <= head.pid;
        end
        if (s_xfer)
        begin
            set_pid_reg <= s_tdata[PID_W-1:0];
            ms_reg      <= s_tdata[PID_W+TW-1:PID_W];
            old_ms_reg  <= '0;
        end
        case (state_reg)
            S_LOOK:
            begin
                rem_reg   <= look_dl - tick_reg;
                alive_reg <= (look_dl != '0) && !reached(tick_reg, look_dl);
            end
            S_MUL:
            begin
                old_ms_reg <= alive_reg ? rem_reg * tm_t'(MS_PER_TICK) : '0;
                big_reg    <= big;
                div_in_reg <= big ? ms_reg : ms_reg * tm_t'(TPS) + tm_t'(ROUND_MS);
            end
            S_FIX:
            begin
                ticks_reg <= big_reg ? tm_t'(q_ms * tm_t'(TPS)) : q_ms;
            end
            S_WHEN:
            begin
                when_reg <= (when_sum == '0) ? tm_t'(1) : when_sum;
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_ms_reg, out_pid_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_queue_compact: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("queue slots not contiguous");

    a_note_no_ms: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_NOTE)) |-> (m_tdata[35:4] == '0))
        else $error("alarm note carries a time");

    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_REPLY)) |-> m_tlast)
        else $error("reply without last");

endmodule
